/* hw/rtl/fcpa_pkg.sv */
// fcpa_pkg: shared types, codes and widths of the fixed chunk pool allocator
// no dependencies; compile first
package fcpa_pkg;

  // field widths
  localparam int ADDR_W   = 48;
  localparam int REQ_W    = 17;
  localparam int TOTAL_W  = 11;
  localparam int STRIDE_W = 18;
  localparam int SPAN_W   = 29;
  localparam int ALIGN_W  = 13;

  // configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 64;

  // parameter defaults
  localparam int MAX_CHUNKS_DEF = 1024;
  localparam int ALIGNMENT_DEF  = 16;
  localparam int ADDR_BITS_DEF  = 48;

  localparam logic [REQ_W-1:0] REQ_RESET = 17'd16;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_ALL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_CHUNK_BYTES = 2'd1,
    REG_CHUNK_TOTAL = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_FILL = 2'd2
  } state_t;

  typedef struct packed {
    logic accept;
    logic fill_start;
    logic fill_step;
    logic complete;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       fill_done;
  } dp_status_t;

endpackage

/* hw/rtl/fcpa_if.sv */
// fcpa_if: request and response channels of the allocator
// depends on fcpa_pkg
interface fcpa_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [fcpa_pkg::ADDR_W-1:0] chunk_address;

  modport source(output valid, output op, output chunk_address, input ready);
  modport sink(input valid, input op, input chunk_address, output ready);
endinterface

interface fcpa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [fcpa_pkg::ADDR_W-1:0] granted_address;
  logic [1:0]                  status;

  modport source(output valid, output granted_address, output status, input ready);
  modport sink(input valid, input granted_address, input status, output ready);
endinterface

/* hw/rtl/fcpa_geom.sv */
// fcpa_geom: pipelined stride and span computation from the configuration
// depends on fcpa_pkg
module fcpa_geom #(
  parameter int ALIGNMENT = fcpa_pkg::ALIGNMENT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [fcpa_pkg::REQ_W-1:0]    requested_chunk_bytes,
  input  logic [fcpa_pkg::TOTAL_W-1:0]  chunk_total,
  output logic [fcpa_pkg::STRIDE_W-1:0] stride,
  output logic [fcpa_pkg::SPAN_W-1:0]   span,
  output logic                          settled
);

  // reciprocal of the alignment, exact for all rounded sizes below 2^18
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << 31) + 64'(ALIGNMENT) - 64'd1) / 64'(ALIGNMENT);
  localparam logic [31:0] RECIP = RECIP_FULL[31:0];
  localparam logic [fcpa_pkg::ALIGN_W-1:0] ALIGN_C = fcpa_pkg::ALIGN_W'(ALIGNMENT);
  localparam logic [fcpa_pkg::STRIDE_W-1:0] ALIGN_M1 = fcpa_pkg::STRIDE_W'(ALIGNMENT - 1);

  logic [fcpa_pkg::STRIDE_W-1:0] rounded;
  logic [49:0]                   quot_prod;
  logic [fcpa_pkg::STRIDE_W-1:0] quot;
  logic [30:0]                   stride_prod;
  logic [1:0]                    settle_cnt;

  assign rounded   = fcpa_pkg::STRIDE_W'(requested_chunk_bytes) + ALIGN_M1;
  assign quot_prod = 50'(rounded) * 50'(RECIP);
  assign stride_prod = 31'(quot) * 31'(ALIGN_C);

  always_ff @(posedge clk) begin
    quot   <= quot_prod[31 +: fcpa_pkg::STRIDE_W];
    stride <= stride_prod[fcpa_pkg::STRIDE_W-1:0];
    span   <= fcpa_pkg::SPAN_W'(stride) * fcpa_pkg::SPAN_W'(chunk_total);
  end

  // three stages to flush after any change
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      settle_cnt <= 2'd3;
    end else if (settle_cnt != 2'd0) begin
      settle_cnt <= settle_cnt - 2'd1;
    end
  end

  assign settled = (settle_cnt == 2'd0);

endmodule

/* hw/rtl/fcpa_dpath.sv */
// fcpa_dpath: free stack memory, free count, fill walker and result register
// depends on fcpa_pkg
module fcpa_dpath #(
  parameter int MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF,
  parameter int ADDR_BITS  = fcpa_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fcpa_pkg::dp_cmd_t             cmd,
  output fcpa_pkg::dp_status_t          status,
  input  logic [1:0]                    req_op,
  input  logic [fcpa_pkg::ADDR_W-1:0]   req_addr,
  input  logic [fcpa_pkg::ADDR_W-1:0]   pool_base,
  input  logic [fcpa_pkg::TOTAL_W-1:0]  chunk_total,
  input  logic [fcpa_pkg::STRIDE_W-1:0] stride,
  input  logic [fcpa_pkg::SPAN_W-1:0]   span,
  output logic [fcpa_pkg::ADDR_W-1:0]   granted_address,
  output logic [1:0]                    result_status
);

  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_CHUNKS);

  logic [ADDR_BITS-1:0] stack_mem [MAX_CHUNKS];
  logic [ADDR_BITS-1:0] rdata;
  logic [CW-1:0]        count;
  logic [CW-1:0]        fill_idx;
  logic [CW-1:0]        fill_n;
  logic                 fill_over;
  logic [ADDR_BITS-1:0] acc;
  logic [1:0]           op_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 pop_hit;
  logic [ADDR_BITS-1:0] granted_q;
  logic [1:0]           status_q;

  logic [63:0]          base64, addr64, stride64, granted64;
  logic [ADDR_BITS-1:0] base_a, addr_in, stride_a, diff;
  logic                 addr_zero, below, beyond, full;
  logic                 pop_ok, push_ok, wr_en, over;
  logic [CW-1:0]        pop_cnt, fill_n_next;
  logic [IW-1:0]        wr_idx;
  logic [ADDR_BITS-1:0] wr_data;
  logic [ADDR_BITS-1:0] granted_next;
  logic [1:0]           status_next;

  // addresses kept to ADDR_BITS bits
  assign base64   = 64'(pool_base);
  assign addr64   = 64'(req_addr);
  assign stride64 = 64'(stride);
  assign base_a   = base64[ADDR_BITS-1:0];
  assign addr_in  = addr64[ADDR_BITS-1:0];
  assign stride_a = stride64[ADDR_BITS-1:0];

  assign addr_zero = (addr_q == '0);
  assign below     = (addr_q < base_a);
  assign diff      = addr_q - base_a;
  assign beyond    = (64'(diff) >= 64'(span));
  assign full      = (count == MAX_C);

  assign pop_cnt = count - CW'(1);
  assign pop_ok  = cmd.accept && (fcpa_pkg::op_t'(req_op) == fcpa_pkg::OP_ALLOC) &&
                   (count != '0);
  assign push_ok = cmd.complete && (fcpa_pkg::op_t'(op_q) == fcpa_pkg::OP_FREE) &&
                   !addr_zero && !below && !beyond && !full;

  assign over        = (32'(chunk_total) > 32'(MAX_CHUNKS));
  assign fill_n_next = over ? MAX_C : CW'(chunk_total);

  assign wr_en   = push_ok || cmd.fill_step;
  assign wr_idx  = cmd.fill_step ? fill_idx[IW-1:0] : count[IW-1:0];
  assign wr_data = cmd.fill_step ? acc : addr_q;

  // one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_idx] <= wr_data;
    end
    if (pop_ok) begin
      rdata <= stack_mem[pop_cnt[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.fill_start) begin
      count <= '0;
    end else if (cmd.fill_step) begin
      count <= fill_idx + CW'(1);
    end else if (pop_ok) begin
      count <= pop_cnt;
    end else if (push_ok) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= req_op;
      addr_q  <= addr_in;
      pop_hit <= pop_ok;
    end
    if (cmd.fill_start) begin
      fill_idx  <= '0;
      fill_n    <= fill_n_next;
      fill_over <= over;
      acc       <= base_a;
    end else if (cmd.fill_step) begin
      fill_idx <= fill_idx + CW'(1);
      acc      <= acc + stride_a;
    end
  end

  always_comb begin
    granted_next = '0;
    status_next  = fcpa_pkg::ST_OK;
    unique case (fcpa_pkg::op_t'(op_q))
      fcpa_pkg::OP_ALLOC: begin
        if (pop_hit) begin
          granted_next = rdata;
        end else begin
          status_next = fcpa_pkg::ST_EMPTY;
        end
      end
      fcpa_pkg::OP_FREE: begin
        if (!addr_zero) begin
          if (below || beyond) begin
            status_next = fcpa_pkg::ST_RANGE;
          end else if (full) begin
            status_next = fcpa_pkg::ST_FULL;
          end
        end
      end
      fcpa_pkg::OP_FREE_ALL: begin
        if (fill_over) begin
          status_next = fcpa_pkg::ST_FULL;
        end
      end
      default: begin
        status_next = fcpa_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.complete) begin
      granted_q <= granted_next;
      status_q  <= status_next;
    end
  end

  assign granted64       = 64'(granted_q);
  assign granted_address = granted64[fcpa_pkg::ADDR_W-1:0];
  assign result_status   = status_q;

  assign status.op        = op_q;
  assign status.fill_done = (fill_idx == fill_n);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_C)
    else $error("free count above stack depth");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_step |-> (fill_idx < fill_n))
    else $error("fill step past chunk count");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop_ok |=> (count == $past(count) - CW'(1)))
    else $error("pop did not lower free count");

endmodule

/* hw/rtl/fcpa_ctrl.sv */
// fcpa_ctrl: sequencing of alloc, free and free-all, and the result valid flag
// depends on fcpa_pkg
module fcpa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic                 geom_settled,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  fcpa_pkg::dp_status_t status,
  output fcpa_pkg::dp_cmd_t    cmd
);

  fcpa_pkg::state_t state, state_next;
  logic             rsp_valid_next;
  logic             slot_free;
  logic             is_fill;

  assign slot_free = !rsp_valid || rsp_ready;
  assign is_fill   = (fcpa_pkg::op_t'(status.op) == fcpa_pkg::OP_FREE_ALL);

  always_comb begin
    state_next = state;
    unique case (state)
      fcpa_pkg::S_IDLE: begin
        if (req_valid && req_ready) begin
          state_next = fcpa_pkg::S_EXEC;
        end
      end
      fcpa_pkg::S_EXEC: begin
        if (is_fill) begin
          state_next = fcpa_pkg::S_FILL;
        end else if (slot_free) begin
          state_next = fcpa_pkg::S_IDLE;
        end
      end
      fcpa_pkg::S_FILL: begin
        if (status.fill_done && slot_free) begin
          state_next = fcpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fcpa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready      = 1'b0;
    cmd            = '0;
    unique case (state)
      fcpa_pkg::S_IDLE: begin
        req_ready  = geom_settled;
        cmd.accept = req_valid && geom_settled;
      end
      fcpa_pkg::S_EXEC: begin
        cmd.fill_start = is_fill;
        cmd.complete   = !is_fill && slot_free;
      end
      fcpa_pkg::S_FILL: begin
        cmd.fill_step = !status.fill_done;
        cmd.complete  = status.fill_done && slot_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.complete) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fcpa_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.complete |-> (!rsp_valid || rsp_ready))
    else $error("result written over an untaken word");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.fill_start, cmd.fill_step, cmd.complete}))
    else $error("conflicting datapath commands");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == fcpa_pkg::S_EXEC))
    else $error("accepted word not executed");

endmodule

/* hw/rtl/fixed_chunk_pool_allocator.sv */
// fixed_chunk_pool_allocator: top level with configuration registers and port wiring
// depends on fcpa_pkg, fcpa_if, fcpa_geom, fcpa_ctrl, fcpa_dpath

// Pool allocator for equal-sized chunks. The pool starts at pool_base and holds
// chunk_total chunks of requested_chunk_bytes rounded up to ALIGNMENT. Free chunk
// addresses live on a last-in-first-out stack in a single-port-write memory.
// Each request word gives exactly one response word. Free and alloc pass the
// accepting cycle and an execute state that loads the response register once the
// last response is taken; alloc reads the stack on accept, free writes it on the
// load. Free-all passes the accepting cycle, the fill start, min(chunk_total,
// MAX_CHUNKS) stack entries written one a cycle and the response load; the request
// side stalls meanwhile. One request is in flight at a time; a new one is accepted
// while the previous response still waits. After any configuration write no
// request is accepted until the stride/span multiplier pipeline has settled.
// Registers sit at byte addresses 0, 8 and 16 of a 64-bit APB port.
module fixed_chunk_pool_allocator #(
  parameter int MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF,
  parameter int ALIGNMENT  = fcpa_pkg::ALIGNMENT_DEF,
  parameter int ADDR_BITS  = fcpa_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  fcpa_req_if.sink                    req,
  fcpa_rsp_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcpa_pkg::APB_AW-1:0] paddr,
  input  logic [fcpa_pkg::APB_DW-1:0] pwdata,
  output logic [fcpa_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  // configuration registers
  logic [fcpa_pkg::ADDR_W-1:0]   pool_base;
  logic [fcpa_pkg::REQ_W-1:0]    requested_chunk_bytes;
  logic [fcpa_pkg::TOTAL_W-1:0]  chunk_total;

  logic                          cfg_write;
  fcpa_pkg::reg_idx_t            reg_idx;

  logic [fcpa_pkg::STRIDE_W-1:0] stride;
  logic [fcpa_pkg::SPAN_W-1:0]   span;
  logic                          geom_settled;

  fcpa_pkg::dp_cmd_t             cmd;
  fcpa_pkg::dp_status_t          dp_status;

  // register index from the 8-byte slot
  assign reg_idx   = fcpa_pkg::reg_idx_t'(paddr[4:3]);
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base             <= '0;
      requested_chunk_bytes <= fcpa_pkg::REQ_RESET;
      chunk_total           <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        fcpa_pkg::REG_POOL_BASE: begin
          pool_base <= pwdata[fcpa_pkg::ADDR_W-1:0];
        end
        fcpa_pkg::REG_CHUNK_BYTES: begin
          requested_chunk_bytes <= pwdata[fcpa_pkg::REQ_W-1:0];
        end
        fcpa_pkg::REG_CHUNK_TOTAL: begin
          chunk_total <= pwdata[fcpa_pkg::TOTAL_W-1:0];
        end
        default: begin
          chunk_total <= chunk_total;
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      fcpa_pkg::REG_POOL_BASE:   prdata = fcpa_pkg::APB_DW'(pool_base);
      fcpa_pkg::REG_CHUNK_BYTES: prdata = fcpa_pkg::APB_DW'(requested_chunk_bytes);
      fcpa_pkg::REG_CHUNK_TOTAL: prdata = fcpa_pkg::APB_DW'(chunk_total);
      default:                   prdata = '0;
    endcase
  end

  // stride = size rounded to alignment, span = stride * chunk count
  fcpa_geom #(
    .ALIGNMENT(ALIGNMENT)
  ) u_geom (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_write            (cfg_write),
    .requested_chunk_bytes(requested_chunk_bytes),
    .chunk_total          (chunk_total),
    .stride               (stride),
    .span                 (span),
    .settled              (geom_settled)
  );

  // sequencing of the three operations
  fcpa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .geom_settled(geom_settled),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (dp_status),
    .cmd         (cmd)
  );

  // free stack, count and response register
  fcpa_dpath #(
    .MAX_CHUNKS(MAX_CHUNKS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (dp_status),
    .req_op         (req.op),
    .req_addr       (req.chunk_address),
    .pool_base      (pool_base),
    .chunk_total    (chunk_total),
    .stride         (stride),
    .span           (span),
    .granted_address(rsp.granted_address),
    .result_status  (rsp.status)
  );

endmodule
